>>> src/srbs_pkg.sv
package srbs_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHIP_TYPE   = 2'd0,
    CFG_BYTE_COUNT  = 2'd1,
    CFG_HALF_PERIOD = 2'd2
  } cfg_idx_t;

  localparam int unsigned MaxBytes = 8;
  localparam int unsigned BitCntW  = $clog2(MaxBytes * 8);      // index of one bit in a scan
  localparam int unsigned TotalW   = $clog2(MaxBytes * 8 + 1);  // holds the bit total itself
  localparam logic [7:0]  HalfPeriodRst = 8'd4;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LATCH = 2'd1,
    PH_LOW   = 2'd2,
    PH_HIGH  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] chip_type;   // bit 1: cd4021, bit 0: pull-up
    logic [3:0] byte_count;
    logic [7:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic       clk_out;
    logic       latch_out;
    logic       busy_res;
    logic       button_valid;
    logic [5:0] button_index;
    logic       button_state;
    logic       last_button;
  } result_t;

endpackage

>>> src/srbs_seq.sv
module srbs_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  srbs_pkg::cfg_t   cfg,
  input  logic             step,     // one accepted item
  input  logic             action,
  input  logic             data_in,
  output srbs_pkg::result_t res      // result of the current item, state after it
);
  import srbs_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [7:0]           delay_r, delay_nxt;
  logic [BitCntW-1:0]   bit_r, bit_nxt;
  logic                 clk_lvl_r, clk_lvl_nxt;
  logic                 latch_lvl_r, latch_lvl_nxt;

  logic                 is_cd4021;
  logic                 is_pull_up;
  logic [3:0]           bytes_sat;
  logic [TotalW-1:0]    total_bits;
  logic [TotalW-1:0]    bit_inc;
  logic                 last_bit;
  logic [7:0]           hp;
  logic [7:0]           delay_inc;
  logic                 half_done;

  assign is_cd4021  = cfg.chip_type[1];
  assign is_pull_up = cfg.chip_type[0];
  assign bytes_sat  = (cfg.byte_count > 4'(MaxBytes)) ? 4'(MaxBytes) : cfg.byte_count;
  assign total_bits = TotalW'({bytes_sat, 3'b000});
  assign bit_inc    = TotalW'(bit_r) + TotalW'(1);
  assign last_bit   = bit_inc >= total_bits;
  assign hp         = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
  assign delay_inc  = delay_r + 8'd1;
  assign half_done  = delay_inc >= hp;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE:  if (action) phase_nxt = PH_LATCH;
      PH_LATCH: if (half_done) phase_nxt = (total_bits == '0) ? PH_IDLE : PH_LOW;
      PH_LOW:   if (half_done) phase_nxt = PH_HIGH;
      PH_HIGH:  if (half_done) phase_nxt = last_bit ? PH_IDLE : PH_LOW;
      default:  phase_nxt = PH_IDLE;
    endcase
  end

  // counters, pin levels and result
  always_comb begin
    delay_nxt     = delay_r;
    bit_nxt       = bit_r;
    clk_lvl_nxt   = clk_lvl_r;
    latch_lvl_nxt = latch_lvl_r;
    res           = '0;
    case (phase_r)
      PH_IDLE: begin
        if (action) begin
          clk_lvl_nxt   = ~is_cd4021;
          latch_lvl_nxt = is_cd4021;
          delay_nxt     = 8'd0;
          bit_nxt       = '0;
        end
      end
      PH_LATCH: begin
        delay_nxt = half_done ? 8'd0 : delay_inc;
        if (half_done) begin
          latch_lvl_nxt = ~is_cd4021;
          if (total_bits != '0) clk_lvl_nxt = 1'b0;
        end
      end
      PH_LOW: begin
        delay_nxt = half_done ? 8'd0 : delay_inc;
        if (half_done) begin
          res.button_valid = 1'b1;
          // first bit of a byte is its highest button
          res.button_index = 6'({bit_r[BitCntW-1:3], ~bit_r[2:0]});
          res.button_state = data_in ^ is_pull_up;
          res.last_button  = last_bit;
          clk_lvl_nxt      = 1'b1;
        end
      end
      PH_HIGH: begin
        delay_nxt = half_done ? 8'd0 : delay_inc;
        if (half_done) begin
          if (last_bit) begin
            bit_nxt = '0;
          end else begin
            bit_nxt     = bit_inc[BitCntW-1:0];
            clk_lvl_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.clk_out   = clk_lvl_nxt;
    res.latch_out = latch_lvl_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      delay_r     <= 8'd0;
      bit_r       <= '0;
      clk_lvl_r   <= 1'b0;
      latch_lvl_r <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      bit_r       <= bit_nxt;
      clk_lvl_r   <= clk_lvl_nxt;
      latch_lvl_r <= latch_lvl_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (delay_r < hp))
    else $error("delay count beyond half period");

  a_idle_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_r == '0))
    else $error("bit count not cleared while idle");

  a_sample_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.button_valid) |=> (phase_r == PH_HIGH && clk_lvl_r))
    else $error("sample not followed by clock-high half");

endmodule

>>> src/shift_register_button_scanner.sv
// Sequencer for one 74HC165 or CD4021 style parallel-in serial-out button chain.
// Every input transaction is one time tick (tuser 0) or a scan start (tuser 1,
// ignored while a scan runs), carrying the sampled serial data pin in tdata bit 0.
// Every input transaction yields exactly one output transaction with the clock
// and latch pin levels and busy flag after that tick; a tick that ends a
// clock-low half also carries a button sample (tuser 1) with its button number,
// and tlast marks the final sample of a scan. A scan pulses the latch for
// half_period_ticks ticks, then clocks min(byte_count,8)*8 bits, each taking two
// half periods. One transaction is taken every clock cycle while the skid
// slot is free: the whole step is a single registered pass, and a two-entry
// output buffer keeps in_tready high while a result waits. Configure only while idle.
module shift_register_button_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] data_in, rest zero
  input  logic                          in_tuser,   // [0] action
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // [0] clk_out, [1] latch_out,
                                                    // [2] busy_res, [8:3] button_index,
                                                    // [9] button_state, rest zero
  output logic                          out_tuser,  // [0] button_valid
  output logic                          out_tlast,  // last_button
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                    cfg_data
);
  import srbs_pkg::*;

  cfg_t    cfg_r;
  result_t step_res;
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;
  logic    in_fire, out_take;

  // configuration registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chip_type         <= 2'd0;
      cfg_r.byte_count        <= 4'd0;
      cfg_r.half_period_ticks <= HalfPeriodRst;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CHIP_TYPE:   cfg_r.chip_type         <= cfg_data[1:0];
        CFG_BYTE_COUNT:  cfg_r.byte_count        <= cfg_data[3:0];
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept while the skid slot is free
  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;

  srbs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step    (in_fire),
    .action  (in_tuser),
    .data_in (in_tdata[0]),
    .res     (step_res)
  );

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : step_res;
    end else if (in_fire) begin
      skid_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.button_state, out_r.button_index,
                       out_r.busy_res, out_r.latch_out, out_r.clk_out};
  assign out_tuser  = out_r.button_valid;
  assign out_tlast  = out_r.last_button;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && in_fire) |=> skid_valid_r)
    else $error("stalled transaction not kept in skid slot");

  a_no_sample_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.button_valid) |->
      (out_r.button_index == 6'd0 && !out_r.button_state && !out_r.last_button))
    else $error("sample fields set without a sample");

  a_last_is_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last_button) |-> out_r.button_valid)
    else $error("last flag without a sample");

endmodule

>>> test/shift_register_button_scanner_tb.sv
`timescale 1ns / 100ps

module shift_register_button_scanner_tb;
  import srbs_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RST_CYCLES = 9;
  // watchdog, far beyond the slowest legal run
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 100;

  // one input transaction: action travels on tuser, data pin level in tdata bit 0
  typedef struct packed {
    logic action;
    logic data_in;
  } scan_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;    // [0] data_in, rest zero
  logic                in_tuser = 1'b0;  // [0] action
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;        // [0] clk_out, [1] latch_out, [2] busy_res,
                                         // [8:3] button_index, [9] button_state
  logic                out_tuser;        // [0] button_valid
  logic                out_tlast;        // last_button
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [7:0]          cfg_data = '0;

  shift_register_button_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // scanner model state, mirrors the pin sequencer
  cfg_t           cur_cfg;
  phase_t         scan_ph;
  logic [7:0]     tick_cnt;
  logic [6:0]     bit_idx;
  logic           sclk_lvl;
  logic           load_lvl;

  scan_item_t     tick_q[$];        // items waiting for the driver
  result_t        pin_results_q[$]; // predicted output transactions, oldest first
  scan_item_t     next_item;
  result_t        want;

  int             n_queued = 0;
  int             n_taken = 0;
  int             n_scans = 0;
  int             n_samples = 0;
  int             n_settings = 0;
  int             n_errors = 0;
  logic           in_fire = 1'b0;   // input transaction completed at the last rising edge
  int             send_idle = 0;    // percent of cycles the sender holds back
  int             recv_stall = 0;   // percent of cycles the receiver stalls
  int             rx_hold = 0;      // forced receiver stall, in cycles

  // counts one tick of the running half period, true when it runs out
  function automatic logic half_elapsed();
    logic [7:0] lim;
    // a zero half period behaves like a single tick
    lim = (cur_cfg.half_period_ticks == 8'd0) ? 8'd1 : cur_cfg.half_period_ticks;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advances the sequencer by one input transaction and returns the pin/sample result
  function automatic result_t advance_scanner(logic act, logic din);
    result_t     r;
    logic        cd4021;
    logic        pull_up;
    int unsigned total;
    r = '0;
    cd4021  = cur_cfg.chip_type[1];
    pull_up = cur_cfg.chip_type[0];
    // byte count saturates at the chain limit
    total = ((cur_cfg.byte_count > MaxBytes) ? MaxBytes : cur_cfg.byte_count) * 8;
    case (scan_ph)
      PH_IDLE: begin
        // start request; a tick while idle leaves everything alone
        if (act) begin
          sclk_lvl = ~cd4021;
          load_lvl = cd4021;
          scan_ph  = PH_LATCH;
          tick_cnt = '0;
          bit_idx  = '0;
          n_scans++;
        end
      end
      PH_LATCH: begin
        if (half_elapsed()) begin
          load_lvl = ~cd4021;
          if (total == 0) begin
            scan_ph = PH_IDLE;
          end else begin
            sclk_lvl = 1'b0;
            scan_ph  = PH_LOW;
          end
        end
      end
      PH_LOW: begin
        // data pin sampled at the end of the clock-low half
        if (half_elapsed()) begin
          r.button_valid = 1'b1;
          // low three bits count down within a byte: 7 - n is the inverse of n
          r.button_index = {bit_idx[5:3], ~bit_idx[2:0]};
          r.button_state = din ^ pull_up;
          r.last_button  = (bit_idx + 1 >= total);
          sclk_lvl = 1'b1;
          scan_ph  = PH_HIGH;
        end
      end
      default: begin
        if (half_elapsed()) begin
          if (bit_idx + 1 >= total) begin
            bit_idx = '0;
            scan_ph = PH_IDLE;
          end else begin
            bit_idx  = bit_idx + 7'd1;
            sclk_lvl = 1'b0;
            scan_ph  = PH_LOW;
          end
        end
      end
    endcase
    r.clk_out   = sclk_lvl;
    r.latch_out = load_lvl;
    r.busy_res  = (scan_ph != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      n_errors++;
    end
  endtask

  // input driver: holds tvalid and tdata until the transaction completes
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      in_fire = 1'b0;
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_item = tick_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= next_item.action;
        in_tdata  <= {7'd0, next_item.data_in};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus a forced hold-off when asked
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: check output transactions, then predict for the input transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pin_results_q.size() == 0) begin
        $error("output transaction with no prediction pending");
        n_errors++;
      end else begin
        want = pin_results_q.pop_front();
        check_field("clk_out", want.clk_out, out_tdata[0]);
        check_field("latch_out", want.latch_out, out_tdata[1]);
        check_field("busy_res", want.busy_res, out_tdata[2]);
        check_field("button_valid", want.button_valid, out_tuser);
        check_field("button_index", want.button_index, out_tdata[8:3]);
        check_field("button_state", want.button_state, out_tdata[9]);
        check_field("last_button", want.last_button, out_tlast);
        if (want.button_valid) n_samples++;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      pin_results_q.push_back(advance_scanner(in_tuser, in_tdata[0]));
      n_taken++;
      in_fire = 1'b1;
    end
  end

  task automatic push_item(logic act, logic din);
    tick_q.push_back('{action: act, data_in: din});
    n_queued++;
  endtask

  // register write through the config channel, model updated on the handshake
  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHIP_TYPE:   cur_cfg.chip_type = val[1:0];
      CFG_BYTE_COUNT:  cur_cfg.byte_count = val[3:0];
      default:         cur_cfg.half_period_ticks = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [1:0] chip, logic [3:0] bytes, logic [7:0] half);
    write_reg(CFG_CHIP_TYPE, {6'd0, chip});
    write_reg(CFG_BYTE_COUNT, {4'd0, bytes});
    write_reg(CFG_HALF_PERIOD, half);
    n_settings++;
  endtask

  // sender waits until every queued item is taken and every result is back
  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || pin_results_q.size() != 0);
    @(posedge clk);
  endtask

  // drain, then tick the running scan out so the block is idle for config writes
  task automatic quiesce();
    drain();
    while (scan_ph != PH_IDLE) begin
      repeat (16) push_item(1'b0, 1'($urandom_range(1)));
      drain();
    end
    repeat (3) @(posedge clk);
  endtask

  // mostly complete scans with random data, some stray starts and random noise
  task automatic gen_scans(int n_items);
    int          pushed;
    int unsigned half;
    int unsigned bits;
    int unsigned len;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(99) < 85) begin
        half = (cur_cfg.half_period_ticks == 8'd0) ? 1 : cur_cfg.half_period_ticks;
        bits = ((cur_cfg.byte_count > MaxBytes) ? MaxBytes : cur_cfg.byte_count) * 8;
        len  = half * (1 + 2 * bits) + $urandom_range(2);
        push_item(1'b1, 1'($urandom_range(1)));
        pushed++;
        // a start inside a scan is ignored, after it a new scan begins
        for (int i = 0; i < len; i++) begin
          push_item(1'($urandom_range(99) < 4), 1'($urandom_range(1)));
          pushed++;
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          push_item(1'($urandom_range(1)), 1'($urandom_range(1)));
          pushed++;
        end
      end
    end
  endtask

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [1:0] chip;
    logic [3:0] bytes;
    logic [7:0] half;
    int         r;

    // model at its reset state
    cur_cfg  = '{chip_type: 2'd0, byte_count: 4'd0, half_period_ticks: HalfPeriodRst};
    scan_ph  = PH_IDLE;
    tick_cnt = '0;
    bit_idx  = '0;
    sclk_lvl = 1'b0;
    load_lvl = 1'b1;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle ticks, then a zero-byte scan that only pulses the latch
    push_item(1'b0, 1'b1);
    push_item(1'b0, 1'b0);
    push_item(1'b1, 1'b1);
    for (int i = 0; i < 4; i++) push_item(1'b0, 1'(i));
    push_item(1'b0, 1'b1);
    quiesce();

    // cd4021 pull-up, one byte, zero half period, a start arriving mid-scan
    set_config(2'd3, 4'd1, 8'd0);
    @(posedge clk);
    push_item(1'b1, 1'b0);
    for (int i = 0; i < 17; i++) push_item(1'(i == 4), 1'(i) ^ 1'(i >> 2));
    quiesce();

    for (int p = 0; p < RAND_PHASES; p++) begin
      // extremes first, then random settings with mostly short scans
      case (p)
        0:       begin chip = 2'd3; bytes = 4'd8;  half = 8'd1;   end
        1:       begin chip = 2'd0; bytes = 4'd15; half = 8'd2;   end
        2:       begin chip = 2'd1; bytes = 4'd0;  half = 8'd255; end
        3:       begin chip = 2'd2; bytes = 4'd1;  half = 8'd0;   end
        default: begin
          chip = 2'($urandom_range(3));
          r = $urandom_range(99);
          bytes = (r < 10) ? 4'd0 : (r < 20) ? 4'($urandom_range(15, 8))
                                             : 4'($urandom_range(3, 1));
          half = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(3, 1));
        end
      endcase
      set_config(chip, bytes, half);
      @(posedge clk);

      // idle pattern: none, sender idle, receiver stall, both lightly
      case (p % 4)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 58; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase

      gen_scans(PHASE_ITEMS);
      // long receiver hold-off while the sender keeps offering, input must back up
      if (p == 4) rx_hold = 60;
      // sender pause mid-phase until every result is back
      if (p == 6) begin
        drain();
        gen_scans(PHASE_ITEMS / 2);
      end
      quiesce();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d input transactions over %0d register settings", n_taken,
             n_settings);
    $display("%0d scans started, %0d button samples checked, %0d mismatches", n_scans,
             n_samples, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
